// ----- hw/rtl/wqf_pkg.sv -----
// wqf_pkg: shared types, constants and rounding helpers for the quaternion fusion block
// no dependencies
package wqf_pkg;

  localparam int FRAC_BITS = 30;
  localparam int QW = 32;
  localparam logic [31:0] INV_SQRT2_Q31 = 32'd1518500250;
  localparam logic [16:0] WEIGHT_ONE = 17'd65536;
  localparam logic [16:0] WEIGHT_RESET = 17'd32768;

  // pipeline shape
  localparam int SQRT_STAGES = 16;
  localparam int SQ_SIDE_W = 3*QW + 1;
  localparam int PIPE_LAT = 25;
  localparam int A_DLY = 21;

  typedef struct packed {
    logic signed [QW-1:0] w;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } q4_t;

  typedef struct packed {
    q4_t  first;
    q4_t  second;
  } in_beat_t;

  typedef struct packed {
    q4_t  fused;
    logic root_clamped;
  } out_beat_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [71:0] hi;
    logic signed [71:0] lo;
    hi = 72'sd2147483647;
    lo = -72'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    if (v < lo) return 32'sh80000000;
    return v[31:0];
  endfunction

  // product of two components, rounded half up by FRAC_BITS
  function automatic logic signed [71:0] fmul_rnd(input logic signed [63:0] p);
    logic signed [71:0] e;
    e = 72'(p) + (72'sd1 <<< (FRAC_BITS - 1));
    return e >>> FRAC_BITS;
  endfunction

  // rotate product rounding, shift 31
  function automatic logic signed [71:0] rot_rnd(input logic signed [67:0] p);
    logic signed [71:0] e;
    e = 72'(p) + (72'sd1 <<< 30);
    return e >>> 31;
  endfunction

endpackage

// ----- hw/rtl/wqf_if.sv -----
// wqf_if: valid/ready channel carrying one packed beat
// depends on wqf_pkg for the beat types
interface wqf_in_if;
  logic                valid;
  logic                ready;
  wqf_pkg::in_beat_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wqf_out_if;
  logic                valid;
  logic                ready;
  wqf_pkg::out_beat_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/wqf_rot.sv -----
// wqf_rot: 45 degree rotation of the y/z pair, one register stage
// depends on wqf_pkg
module wqf_rot (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [31:0]    a_y,
  input  logic signed [31:0]    a_z,
  output logic signed [31:0]    r_y,
  output logic signed [31:0]    r_z
);
  import wqf_pkg::*;

  logic signed [32:0] sum_w;
  logic signed [32:0] dif_w;
  logic signed [67:0] ps_w;
  logic signed [67:0] pd_w;
  logic signed [31:0] r_y_r;
  logic signed [31:0] r_z_r;

  assign sum_w = 33'(a_y) + 33'(a_z);
  assign dif_w = 33'(a_y) - 33'(a_z);
  assign ps_w  = 68'(sum_w) * 68'(signed'({1'b0, INV_SQRT2_Q31}));
  assign pd_w  = 68'(dif_w) * 68'(signed'({1'b0, INV_SQRT2_Q31}));

  always_ff @(posedge clk) begin
    if (en) begin
      r_y_r <= sat32(rot_rnd(ps_w));
      r_z_r <= sat32(rot_rnd(pd_w));
    end
  end

  assign r_y = r_y_r;
  assign r_z = r_z_r;
endmodule

// ----- hw/rtl/wqf_qmul.sv -----
// wqf_qmul: 16 rounded component products registered, then signed sums registered
// depends on wqf_pkg; sign pattern chosen by conj_a (conj(a)*b) or not (x*a)
module wqf_qmul (
  input  logic        clk,
  input  logic        en1,
  input  logic        en2,
  input  logic        conj_a,
  input  wqf_pkg::q4_t a,
  input  wqf_pkg::q4_t b,
  output wqf_pkg::q4_t p
);
  import wqf_pkg::*;

  logic signed [31:0] av [4];
  logic signed [31:0] bv [4];
  logic signed [33:0] prod_r [4][4];
  logic signed [33:0] prod_nxt [4][4];
  logic signed [35:0] s_w [4];
  q4_t p_r;

  assign av = '{a.w, a.x, a.y, a.z};
  assign bv = '{b.w, b.x, b.y, b.z};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_nxt[i][j] = 34'(fmul_rnd(64'(av[i]) * 64'(bv[j])));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) prod_r <= prod_nxt;
  end

  // prod_r[i][j] = a_i * b_j
  always_comb begin
    if (conj_a) begin
      s_w[0] = 36'(prod_r[0][0]) + 36'(prod_r[1][1]) + 36'(prod_r[2][2]) + 36'(prod_r[3][3]);
      s_w[1] = -36'(prod_r[1][0]) + 36'(prod_r[0][1]) + 36'(prod_r[2][3]) - 36'(prod_r[3][2]);
      s_w[2] = -36'(prod_r[2][0]) + 36'(prod_r[0][2]) + 36'(prod_r[3][1]) - 36'(prod_r[1][3]);
      s_w[3] = -36'(prod_r[3][0]) + 36'(prod_r[0][3]) + 36'(prod_r[1][2]) - 36'(prod_r[2][1]);
    end else begin
      // a is x, b is the first quaternion
      s_w[0] = 36'(prod_r[0][0]) - 36'(prod_r[1][1]) - 36'(prod_r[2][2]) - 36'(prod_r[3][3]);
      s_w[1] = 36'(prod_r[1][0]) + 36'(prod_r[0][1]) + 36'(prod_r[2][3]) - 36'(prod_r[3][2]);
      s_w[2] = 36'(prod_r[2][0]) + 36'(prod_r[0][2]) + 36'(prod_r[3][1]) - 36'(prod_r[1][3]);
      s_w[3] = 36'(prod_r[3][0]) + 36'(prod_r[0][3]) + 36'(prod_r[1][2]) - 36'(prod_r[2][1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      p_r.w <= sat32(72'(s_w[0]));
      p_r.x <= sat32(72'(s_w[1]));
      p_r.y <= sat32(72'(s_w[2]));
      p_r.z <= sat32(72'(s_w[3]));
    end
  end

  assign p = p_r;
endmodule

// ----- hw/rtl/wqf_sqrt.sv -----
// wqf_sqrt: pipelined restoring square root, two result bits per stage, rounded
// depends on wqf_pkg; carries a side payload alongside the root
module wqf_sqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [61:0]                  arg,
  input  logic [wqf_pkg::SQ_SIDE_W-1:0] side_in,
  output logic [31:0]                  root,
  output logic [wqf_pkg::SQ_SIDE_W-1:0] side_out
);
  import wqf_pkg::*;

  logic [63:0]          rem_r  [SQRT_STAGES];
  logic [31:0]          res_r  [SQRT_STAGES];
  logic [SQ_SIDE_W-1:0] side_r [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_st
    logic [63:0]          rm_in;
    logic [31:0]          rs_in;
    logic [SQ_SIDE_W-1:0] sd_in;
    logic [63:0]          rm;
    logic [31:0]          rs;
    logic [65:0]          trial;
    if (s == 0) begin : g_first
      assign rm_in = 64'(arg);
      assign rs_in = '0;
      assign sd_in = side_in;
    end else begin : g_next
      assign rm_in = rem_r[s-1];
      assign rs_in = res_r[s-1];
      assign sd_in = side_r[s-1];
    end
    always_comb begin
      rm = rm_in;
      rs = rs_in;
      trial = '0;
      for (int k = 0; k < 2; k++) begin
        trial = 66'(rm >> (2*(31 - (2*s + k)))) - 66'({rs, 2'b01});
        if (!trial[65]) begin
          rm = rm - (64'({rs, 2'b01}) << (2*(31 - (2*s + k))));
          rs = {rs[30:0], 1'b1};
        end else begin
          rs = {rs[30:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rm;
        res_r[s]  <= rs;
        side_r[s] <= sd_in;
      end
    end
  end

  // round to nearest: remainder above root means next integer
  assign root     = (rem_r[SQRT_STAGES-1] > 64'(res_r[SQRT_STAGES-1])) ?
                    res_r[SQRT_STAGES-1] + 32'd1 : res_r[SQRT_STAGES-1];
  assign side_out = side_r[SQRT_STAGES-1];
endmodule

// ----- hw/rtl/weighted_quaternion_fusion.sv -----
// weighted_quaternion_fusion: top level of the quaternion fusion pipeline
// depends on wqf_pkg, wqf_if, wqf_rot, wqf_qmul, wqf_sqrt
//
// Fuses two Q1.30 attitude quaternions into one, weighting the relative
// rotation by cfg_combine_weight (Q1.16, values above 1.0 act as 1.0).
// One beat is accepted every clock cycle while the pipeline advances. Stages from
// input beat to output beat: rotate in 1, relative product 2-3, weighting 4,
// squares 5, root argument 6, square root 7-22, final product 23-24,
// rotate back 25. The pipeline advances as a whole whenever the output
// register is empty or being taken, so a stall holds every stage in place.
// Depth is set by the 16-stage square root, two result bits per stage.
module weighted_quaternion_fusion (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [16:0]        cfg_combine_weight,
  wqf_in_if.sink             in_ch,
  wqf_out_if.source          out_ch
);
  import wqf_pkg::*;

  logic [16:0]         weight_r;
  logic [PIPE_LAT-1:0] vld_r;
  logic                adv;

  // whole-pipeline enable
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_RESET;
      vld_r    <= '0;
    end else begin
      if (cfg_we) weight_r <= cfg_combine_weight;
      if (adv) vld_r <= {vld_r[PIPE_LAT-2:0], in_ch.valid};
    end
  end

  // stage 1: rotate both inputs
  logic signed [31:0] a1w_r, a1x_r, b1w_r, b1x_r;
  logic signed [31:0] a1_y, a1_z, b1_y, b1_z;
  q4_t a1, b1;
  wqf_rot u_rot_a (.clk, .en(adv), .a_y(in_ch.data.first.y), .a_z(in_ch.data.first.z),
                   .r_y(a1_y), .r_z(a1_z));
  wqf_rot u_rot_b (.clk, .en(adv), .a_y(in_ch.data.second.y), .a_z(in_ch.data.second.z),
                   .r_y(b1_y), .r_z(b1_z));
  always_ff @(posedge clk) begin
    if (adv) begin
      a1w_r <= in_ch.data.first.w;
      a1x_r <= in_ch.data.first.x;
      b1w_r <= in_ch.data.second.w;
      b1x_r <= in_ch.data.second.x;
    end
  end
  assign a1 = {a1w_r, a1x_r, a1_y, a1_z};
  assign b1 = {b1w_r, b1x_r, b1_y, b1_z};

  // stages 2-3: relative quaternion conj(a) * b
  q4_t d3;
  wqf_qmul u_rel (.clk, .en1(adv), .en2(adv), .conj_a(1'b1), .a(a1), .b(b1), .p(d3));

  // first quaternion delay line to match the root stage
  q4_t a_dly [A_DLY];
  always_ff @(posedge clk) begin
    if (adv) begin
      a_dly[0] <= a1;
      for (int i = 1; i < A_DLY; i++) a_dly[i] <= a_dly[i-1];
    end
  end

  // stage 4: sign flip and weighting
  logic [16:0] w_eff;
  logic signed [31:0] f_w [3];
  logic signed [31:0] xv_r [3];
  assign w_eff = (weight_r > WEIGHT_ONE) ? WEIGHT_ONE : weight_r;
  assign f_w[0] = d3.w[31] ? sat32(-72'(d3.x)) : d3.x;
  assign f_w[1] = d3.w[31] ? sat32(-72'(d3.y)) : d3.y;
  assign f_w[2] = d3.w[31] ? sat32(-72'(d3.z)) : d3.z;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        xv_r[i] <= sat32(((72'(f_w[i]) * 72'(signed'({1'b0, w_eff}))) + 72'sd32768) >>> 16);
      end
    end
  end

  // stage 5: squares
  logic [63:0] sq_r [3];
  logic signed [31:0] xv5_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i]  <= 64'(64'(xv_r[i]) * 64'(xv_r[i]));
        xv5_r[i] <= xv_r[i];
      end
    end
  end

  // stage 6: argument and clamp
  logic [65:0] sumsq_w;
  logic [61:0] arg_r;
  logic        clamp_r;
  logic signed [31:0] xv6_r [3];
  assign sumsq_w = 66'(sq_r[0]) + 66'(sq_r[1]) + 66'(sq_r[2]);
  always_ff @(posedge clk) begin
    if (adv) begin
      clamp_r <= sumsq_w > (66'd1 << (2*FRAC_BITS));
      arg_r   <= (sumsq_w > (66'd1 << (2*FRAC_BITS))) ? '0
                 : 62'((66'd1 << (2*FRAC_BITS)) - sumsq_w);
      xv6_r   <= xv5_r;
    end
  end

  // stages 7-22: square root
  logic [31:0] root_w;
  logic [SQ_SIDE_W-1:0] side_w;
  wqf_sqrt u_sqrt (
    .clk, .en(adv), .arg(arg_r),
    .side_in({xv6_r[0], xv6_r[1], xv6_r[2], clamp_r}),
    .root(root_w), .side_out(side_w)
  );

  q4_t x22;
  logic clamp22;
  assign x22.w = clamp22 ? '0 : sat32(72'(root_w));
  assign x22.x = side_w[SQ_SIDE_W-1 -: 32];
  assign x22.y = side_w[SQ_SIDE_W-33 -: 32];
  assign x22.z = side_w[SQ_SIDE_W-65 -: 32];
  assign clamp22 = side_w[0];

  // stages 23-24: x * a
  q4_t t24;
  logic clamp_d [3];
  wqf_qmul u_fin (.clk, .en1(adv), .en2(adv), .conj_a(1'b0), .a(x22), .b(a_dly[A_DLY-1]),
                  .p(t24));
  always_ff @(posedge clk) begin
    if (adv) begin
      clamp_d[0] <= clamp22;
      clamp_d[1] <= clamp_d[0];
      clamp_d[2] <= clamp_d[1];
    end
  end

  // stage 25: rotate back
  logic signed [31:0] s25w_r, s25x_r, s25_y, s25_z;
  wqf_rot u_rot_o (.clk, .en(adv), .a_y(t24.y), .a_z(t24.z), .r_y(s25_y), .r_z(s25_z));
  always_ff @(posedge clk) begin
    if (adv) begin
      s25w_r <= t24.w;
      s25x_r <= t24.x;
    end
  end

  assign out_ch.valid             = vld_r[PIPE_LAT-1];
  assign out_ch.data.fused        = {s25w_r, s25x_r, s25_y, s25_z};
  assign out_ch.data.root_clamped = clamp_d[2];

  // a stalled pipeline keeps its valid bits
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r)) else $error("valid bits moved during stall");
  // input is taken exactly when the output register is free or being drained
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == (!out_ch.valid || out_ch.ready)) else $error("ready mismatch");
endmodule

// ----- test/weighted_quaternion_fusion_chk.sv -----
`timescale 1ns / 1ps
// weighted_quaternion_fusion_chk: watches both channels, predicts each fused beat and compares
// depends on wqf_pkg and the wqf_in_if / wqf_out_if channel interfaces
module weighted_quaternion_fusion_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [16:0] cfg_combine_weight,
  wqf_in_if           in_mon,
  wqf_out_if          out_mon,
  output int          fail_count,
  output int          fused_pending
);
  import wqf_pkg::*;

  typedef logic signed [71:0] wide_t;

  logic [16:0] weight_q;
  out_beat_t   fused_expected [$];

  function automatic wide_t round_shift(wide_t v, int s);
    return (v + (wide_t'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic wide_t clip32(wide_t v);
    if (v > wide_t'(64'sd2147483647)) return wide_t'(64'sd2147483647);
    if (v < wide_t'(-64'sd2147483648)) return wide_t'(-64'sd2147483648);
    return v;
  endfunction

  function automatic wide_t qmul(wide_t a, wide_t b);
    return round_shift(a * b, FRAC_BITS);
  endfunction

  // 45 degree turn in the y/z plane, one output component
  function automatic wide_t turn45(wide_t a, wide_t b);
    return clip32(round_shift((a + b) * wide_t'(longint'(INV_SQRT2_Q31)), 31));
  endfunction

  function automatic logic [63:0] root_nearest(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n = n - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    if (n > r) r = r + 1;
    return r;
  endfunction

  function automatic out_beat_t fuse_predict(in_beat_t beat, logic [16:0] wcfg);
    wide_t     a [4];
    wide_t     b [4];
    wide_t     d [4];
    wide_t     x [4];
    wide_t     t [4];
    wide_t     wt;
    wide_t     sumsq;
    wide_t     one2;
    logic      clamped;
    int        j, k, m;
    out_beat_t res;
    wt = (wcfg > WEIGHT_ONE) ? wide_t'(WEIGHT_ONE) : wide_t'(wcfg);
    a[0] = wide_t'(beat.first.w);
    a[1] = wide_t'(beat.first.x);
    a[2] = turn45(wide_t'(beat.first.y), wide_t'(beat.first.z));
    a[3] = turn45(wide_t'(beat.first.y), -wide_t'(beat.first.z));
    b[0] = wide_t'(beat.second.w);
    b[1] = wide_t'(beat.second.x);
    b[2] = turn45(wide_t'(beat.second.y), wide_t'(beat.second.z));
    b[3] = turn45(wide_t'(beat.second.y), -wide_t'(beat.second.z));
    // relative rotation conj(a) * b
    d[0] = clip32(qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]) + qmul(a[3], b[3]));
    for (int i = 0; i < 3; i++) begin
      j = 1 + i;
      k = 1 + (i + 1) % 3;
      m = 1 + (i + 2) % 3;
      d[j] = clip32(-qmul(a[j], b[0]) + qmul(a[0], b[j]) + qmul(a[k], b[m]) - qmul(a[m], b[k]));
    end
    if (d[0] < 0)
      for (int i = 0; i < 4; i++) d[i] = clip32(-d[i]);
    sumsq = 0;
    for (int i = 1; i < 4; i++) begin
      x[i] = clip32(round_shift(d[i] * wt, 16));
      sumsq = sumsq + x[i] * x[i];
    end
    one2 = wide_t'(1) <<< (2 * FRAC_BITS);
    clamped = sumsq > one2;
    x[0] = clamped ? wide_t'(0) : clip32(wide_t'(root_nearest(64'(one2 - sumsq))));
    t[0] = clip32(qmul(x[0], a[0]) - qmul(x[1], a[1]) - qmul(x[2], a[2]) - qmul(x[3], a[3]));
    for (int i = 0; i < 3; i++) begin
      j = 1 + i;
      k = 1 + (i + 1) % 3;
      m = 1 + (i + 2) % 3;
      t[j] = clip32(qmul(x[j], a[0]) + qmul(x[0], a[j]) + qmul(x[k], a[m]) - qmul(x[m], a[k]));
    end
    res.fused.w = t[0][31:0];
    res.fused.x = t[1][31:0];
    res.fused.y = 32'(turn45(t[2], t[3]));
    res.fused.z = 32'(turn45(t[2], -t[3]));
    res.root_clamped = clamped;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count    = 0;
    fused_pending = 0;
  end

  always @(posedge clk) begin
    out_beat_t want;
    out_beat_t got;
    if (!rst_n) begin
      weight_q <= 17'd32768;
    end else begin
      if (cfg_we) weight_q <= cfg_combine_weight;
      if (in_mon.valid && in_mon.ready)
        fused_expected.push_back(fuse_predict(in_mon.data, weight_q));
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (fused_expected.size() == 0) begin
          report_mismatch("unexpected beat", got.fused.w, 32'h0);
        end else begin
          want = fused_expected.pop_front();
          if (got.fused.w !== want.fused.w) report_mismatch("fused_w", got.fused.w, want.fused.w);
          if (got.fused.x !== want.fused.x) report_mismatch("fused_x", got.fused.x, want.fused.x);
          if (got.fused.y !== want.fused.y) report_mismatch("fused_y", got.fused.y, want.fused.y);
          if (got.fused.z !== want.fused.z) report_mismatch("fused_z", got.fused.z, want.fused.z);
          if (got.root_clamped !== want.root_clamped)
            report_mismatch("root_clamped", 32'(got.root_clamped), 32'(want.root_clamped));
        end
      end
    end
    fused_pending <= fused_expected.size();
  end

endmodule

// ----- test/weighted_quaternion_fusion_tb.sv -----
`timescale 1ns / 1ps
// weighted_quaternion_fusion_tb: stimulus, idling phases and verdict for the fusion block
// depends on wqf_pkg, the channel interfaces, the block and weighted_quaternion_fusion_chk
module weighted_quaternion_fusion_tb;
  import wqf_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_BEATS    = 175;
  localparam logic signed [31:0] Q_ONE = 32'sd1073741824;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [16:0] cfg_combine_weight;
  int          fail_count;
  int          fused_pending;

  wqf_in_if  in_ch ();
  wqf_out_if out_ch ();

  // idling knobs, per cent of cycles
  int sender_idle_pct;
  int receiver_stall_pct;
  // long receiver hold-off requests, served in the receiver process
  int hold_requests;
  int hold_served;
  int idle_cycles;

  weighted_quaternion_fusion dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_combine_weight (cfg_combine_weight),
    .in_ch              (in_ch),
    .out_ch             (out_ch)
  );

  weighted_quaternion_fusion_chk chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_combine_weight (cfg_combine_weight),
    .in_mon             (in_ch),
    .out_mon            (out_ch),
    .fail_count         (fail_count),
    .fused_pending      (fused_pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // random component over the full legal span, both ends included
  function automatic logic signed [31:0] rand_comp();
    return 32'(longint'($urandom_range(32'h8000_0000, 0)) - 64'sd1073741824);
  endfunction

  // either an extreme or a random component
  function automatic logic signed [31:0] edge_comp();
    case ($urandom_range(5, 0))
      0: return Q_ONE;
      1: return -Q_ONE;
      2: return 32'sd0;
      3: return 32'sd1;
      4: return -32'sd1;
      default: return rand_comp();
    endcase
  endfunction

  // second quaternion close to the first, so the relative rotation stays small
  function automatic logic signed [31:0] nudge(logic signed [31:0] c);
    longint v;
    v = longint'(c) + longint'($urandom_range(32'h0200_0000, 0)) - 64'sd16777216;
    if (v > 64'sd1073741824) v = 64'sd1073741824;
    if (v < -64'sd1073741824) v = -64'sd1073741824;
    return 32'(v);
  endfunction

  function automatic q4_t make_q(logic signed [31:0] w, logic signed [31:0] x,
                                 logic signed [31:0] y, logic signed [31:0] z);
    q4_t q;
    q.w = w;
    q.x = x;
    q.y = y;
    q.z = z;
    return q;
  endfunction

  function automatic in_beat_t random_pair();
    in_beat_t b;
    int       pick;
    pick = $urandom_range(99, 0);
    if (pick < 60) begin
      // near-identical attitudes with half-scale components
      b.first = make_q(rand_comp() >>> 1, rand_comp() >>> 1, rand_comp() >>> 1,
                       rand_comp() >>> 1);
      b.second = make_q(nudge(b.first.w), nudge(b.first.x), nudge(b.first.y),
                        nudge(b.first.z));
    end else if (pick < 80) begin
      b.first  = make_q(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      b.second = make_q(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    end else begin
      b.first  = make_q(edge_comp(), edge_comp(), edge_comp(), edge_comp());
      b.second = make_q(edge_comp(), edge_comp(), edge_comp(), edge_comp());
    end
    return b;
  endfunction

  // offer one beat and hold it until taken, then maybe idle
  task automatic send_beat(in_beat_t b);
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // park the input and wait until every predicted beat has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (fused_pending != 0) @(posedge clk);
  endtask

  // register writes only happen with the pipeline empty
  task automatic write_weight(logic [16:0] value);
    drain();
    cfg_we             <= 1'b1;
    cfg_combine_weight <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    hold_served  = 0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        // long hold-off while the sender keeps offering, so the pipe backs up
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_served++;
      end
      out_ch.ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    in_beat_t    b;
    logic [16:0] phase_weight [5];
    int          stall_plan [5];
    int          idle_plan  [5];
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_combine_weight = 17'd0;
    in_ch.valid        = 1'b0;
    in_ch.data         = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_requests      = 0;
    idle_cycles        = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats under the reset weight first
    b.first  = make_q(32'sd0, 32'sd0, 32'sd0, 32'sd0);
    b.second = b.first;
    send_beat(b);
    b.first  = make_q(Q_ONE, 32'sd0, 32'sd0, 32'sd0);
    b.second = b.first;
    send_beat(b);
    // opposite attitudes: scalar part of the relative rotation goes negative
    b.second = make_q(-Q_ONE, 32'sd0, 32'sd0, 32'sd0);
    send_beat(b);
    b.first  = make_q(Q_ONE, Q_ONE, Q_ONE, Q_ONE);
    b.second = make_q(-Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE);
    send_beat(b);
    // y and z at opposite extremes stress the 45 degree turn
    b.first  = make_q(-Q_ONE, Q_ONE, Q_ONE, -Q_ONE);
    b.second = make_q(Q_ONE, -Q_ONE, -Q_ONE, Q_ONE);
    send_beat(b);

    // full weight: a large vector part overflows the root argument and clamps
    write_weight(WEIGHT_ONE);
    b.first  = make_q(Q_ONE, 32'sd0, 32'sd0, 32'sd0);
    b.second = make_q(32'sd0, Q_ONE, 32'sd0, 32'sd0);
    send_beat(b);
    b.second = make_q(32'sd0, Q_ONE, Q_ONE, Q_ONE);
    send_beat(b);
    b.second = make_q(Q_ONE, Q_ONE, -Q_ONE, Q_ONE);
    send_beat(b);
    b.first  = make_q(Q_ONE, Q_ONE, Q_ONE, Q_ONE);
    b.second = make_q(Q_ONE, -Q_ONE, Q_ONE, -Q_ONE);
    send_beat(b);
    b.first  = make_q(32'sd1, -32'sd1, 32'sd1, -32'sd1);
    b.second = make_q(-32'sd1, 32'sd1, -32'sd1, 32'sd1);
    send_beat(b);

    // weight above one acts as one, weight zero drops the relative rotation
    write_weight(17'h1ffff);
    b.first  = make_q(Q_ONE, 32'sd0, 32'sd0, 32'sd0);
    b.second = make_q(32'sd0, 32'sd0, Q_ONE, 32'sd0);
    send_beat(b);
    write_weight(17'd0);
    send_beat(b);
    b.first  = make_q(-Q_ONE, Q_ONE, -Q_ONE, Q_ONE);
    b.second = make_q(Q_ONE, Q_ONE, Q_ONE, Q_ONE);
    send_beat(b);

    // random phases, each with its own weight and idling pattern
    phase_weight[0] = 17'd32768;
    phase_weight[1] = 17'd65536;
    phase_weight[2] = 17'd65537;
    phase_weight[3] = 17'(longint'($urandom_range(65536, 0)));
    phase_weight[4] = 17'd1;
    idle_plan[0] = 0;   stall_plan[0] = 0;
    idle_plan[1] = 65;  stall_plan[1] = 0;
    idle_plan[2] = 0;   stall_plan[2] = 65;
    idle_plan[3] = 32;  stall_plan[3] = 32;
    idle_plan[4] = 0;   stall_plan[4] = 0;
    for (int p = 0; p < 5; p++) begin
      write_weight(phase_weight[p]);
      sender_idle_pct    = idle_plan[p];
      receiver_stall_pct = stall_plan[p];
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (p == 0 && n == 40) hold_requests++;
        // sender waits for the pipe to empty before carrying on
        if (p == 3 && n == 90) drain();
        send_beat(random_pair());
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && fused_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/wqf_pkg.sv
hw/rtl/wqf_if.sv
hw/rtl/wqf_rot.sv
hw/rtl/wqf_qmul.sv
hw/rtl/wqf_sqrt.sv
hw/rtl/weighted_quaternion_fusion.sv
test/weighted_quaternion_fusion_chk.sv
test/weighted_quaternion_fusion_tb.sv
